>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with synchronous reset masking
`define QPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// same-cycle implication built on the macro above
`define QPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   `QPP_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

>>> sv/qpp_pkg.sv
// shared constants, types and helpers of the projection core
// no dependencies
package qpp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int Q_W             = 32;
   localparam int FOCAL_W         = 32;
   localparam int CSR_IDX_W       = 3;
   localparam int QP_W            = 34;
   localparam int R_W             = 36;
   localparam int D_LO_W          = 16;
   // pipeline stages outside the divider: eight front stages and the output stage
   localparam int FIXED_STAGES    = 9;

   localparam logic signed [R_W-1:0] ONE_Q30 = 36'sd1073741824;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROT_QW,
      REG_ROT_QX,
      REG_ROT_QY,
      REG_ROT_QZ,
      REG_CAM_X,
      REG_CAM_Y,
      REG_CAM_Z,
      REG_FOCAL
   } csr_reg_type;

   // control bits travelling with each item
   typedef struct packed {
      logic valid;
      logic last;
      logic dz;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } side_type;

   // q2.30 product rounded half up
   function automatic logic signed [QP_W-1:0] qprod(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return p[63:30];
   endfunction

endpackage

>>> sv/quaternion_perspective_projection_core.sv
// top level of the quaternion rotation and pinhole projection pipeline
// depends on qpp_pkg and qpp_div
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-------------------------------
//   input    | req_point_x/y/z, req_last_in   | taken when start && !busy
//   result   | rsp_screen_x/y, rsp_depth_zero,| rsp_valid strobe, one cycle
//            | rsp_saturated, rsp_last_out    |
//   config   | csr_we, csr_index, csr_wdata   | written when csr_we is high
//
// one item per cycle while busy is low; the path runs through the eight front
// stages (subtract, rotation matrix, partial products, sums, signs, focal multiply,
// dividends, overflow check), the divider with one quotient bit per stage, and the
// output register. busy is high during reset and in the first cycle after it;
// reset clears the control bits and loads the configuration defaults.
// the receiver cannot stall, so the pipeline never holds.
module quaternion_perspective_projection_core #(
   parameter int COORD_WIDTH = qpp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   input  logic signed [COORD_WIDTH-1:0]        req_point_z,
   input  logic                                 req_last_in,
   output logic                                 rsp_valid,
   output logic signed [COORD_WIDTH-1:0]        rsp_screen_x,
   output logic signed [COORD_WIDTH-1:0]        rsp_screen_y,
   output logic                                 rsp_depth_zero,
   output logic                                 rsp_saturated,
   output logic                                 rsp_last_out,
   input  logic                                 csr_we,
   input  logic [qpp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qpp_pkg::Q_W-1:0]              csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int D_W   = CW + 1;
   localparam int DL_W  = qpp_pkg::D_LO_W;
   localparam int DH_W  = D_W - DL_W;
   localparam int R_W   = qpp_pkg::R_W;
   localparam int ACC_W = CW + 39;
   localparam int V_W   = ACC_W - 30;
   localparam int ML_W  = V_W / 2;
   localparam int MH_W  = V_W - ML_W;
   localparam int F_W   = qpp_pkg::FOCAL_W;
   localparam int N_W   = V_W + F_W;
   localparam int PL_W  = R_W + DL_W + 1;
   localparam int PH_W  = R_W + DH_W;

   // configuration registers
   logic signed [qpp_pkg::Q_W-1:0] rot_ff [4];
   logic [qpp_pkg::Q_W-1:0]        cam_ff [3];
   logic [F_W-1:0]                 focal_ff;
   logic                           busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 32'sd1073741824;
         rot_ff[1] <= '0;
         rot_ff[2] <= '0;
         rot_ff[3] <= '0;
         cam_ff[0] <= '0;
         cam_ff[1] <= '0;
         cam_ff[2] <= '0;
         focal_ff  <= 32'd65536;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (qpp_pkg::csr_reg_type'(csr_index))
               qpp_pkg::REG_ROT_QW: rot_ff[0] <= csr_wdata;
               qpp_pkg::REG_ROT_QX: rot_ff[1] <= csr_wdata;
               qpp_pkg::REG_ROT_QY: rot_ff[2] <= csr_wdata;
               qpp_pkg::REG_ROT_QZ: rot_ff[3] <= csr_wdata;
               qpp_pkg::REG_CAM_X:  cam_ff[0] <= csr_wdata;
               qpp_pkg::REG_CAM_Y:  cam_ff[1] <= csr_wdata;
               qpp_pkg::REG_CAM_Z:  cam_ff[2] <= csr_wdata;
               qpp_pkg::REG_FOCAL:  focal_ff  <= csr_wdata;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   // camera coordinates at coordinate width (zero padded above 32 bits)
   logic signed [CW-1:0] cam_c [3];
   for (genvar i = 0; i < 3; i++) begin : g_cam
      if (CW > 32) begin : g_wide
         assign cam_c[i] = {{(CW-32){1'b0}}, cam_ff[i]};
      end else begin : g_narrow
         assign cam_c[i] = cam_ff[i][CW-1:0];
      end
   end

   logic signed [CW-1:0] pt [3];
   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;

   // stage 1: difference vector and quaternion products
   qpp_pkg::side_type               s1_ff;
   qpp_pkg::side_type               s1_in;
   logic signed [D_W-1:0]           d1_ff [3];
   logic signed [qpp_pkg::QP_W-1:0] qp_ff [9];

   always_comb begin
      s1_in       = '0;
      s1_in.valid = start && !busy_ff;
      s1_in.last  = req_last_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d1_ff[i] <= D_W'(pt[i]) - D_W'(cam_c[i]);
      end
      qp_ff[0] <= qpp_pkg::qprod(rot_ff[1], rot_ff[1]);
      qp_ff[1] <= qpp_pkg::qprod(rot_ff[2], rot_ff[2]);
      qp_ff[2] <= qpp_pkg::qprod(rot_ff[3], rot_ff[3]);
      qp_ff[3] <= qpp_pkg::qprod(rot_ff[1], rot_ff[2]);
      qp_ff[4] <= qpp_pkg::qprod(rot_ff[1], rot_ff[3]);
      qp_ff[5] <= qpp_pkg::qprod(rot_ff[2], rot_ff[3]);
      qp_ff[6] <= qpp_pkg::qprod(rot_ff[0], rot_ff[1]);
      qp_ff[7] <= qpp_pkg::qprod(rot_ff[0], rot_ff[2]);
      qp_ff[8] <= qpp_pkg::qprod(rot_ff[0], rot_ff[3]);
      if (reset) s1_ff <= '0;
      else       s1_ff <= s1_in;
   end

   // stage 2: rotation matrix
   qpp_pkg::side_type     s2_ff;
   logic signed [D_W-1:0] d2_ff [3];
   logic signed [R_W-1:0] r_ff  [9];
   logic signed [R_W-1:0] e     [9];
   logic signed [R_W-1:0] r_in  [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = R_W'(qp_ff[i]);
      end
      r_in[0] = qpp_pkg::ONE_Q30 - ((e[1] + e[2]) <<< 1);
      r_in[1] = (e[3] - e[8]) <<< 1;
      r_in[2] = (e[4] + e[7]) <<< 1;
      r_in[3] = (e[3] + e[8]) <<< 1;
      r_in[4] = qpp_pkg::ONE_Q30 - ((e[0] + e[2]) <<< 1);
      r_in[5] = (e[5] - e[6]) <<< 1;
      r_in[6] = (e[4] - e[7]) <<< 1;
      r_in[7] = (e[5] + e[6]) <<< 1;
      r_in[8] = qpp_pkg::ONE_Q30 - ((e[0] + e[1]) <<< 1);
   end

   always_ff @(posedge clock) begin
      r_ff  <= r_in;
      d2_ff <= d1_ff;
      if (reset) s2_ff <= '0;
      else       s2_ff <= s1_ff;
   end

   // stage 3: partial products of matrix and vector, low and high halves of d
   qpp_pkg::side_type      s3_ff;
   logic signed [PL_W-1:0] pl_ff [9];
   logic signed [PH_W-1:0] ph_ff [9];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pl_ff[3*i+j] <= r_ff[3*i+j] * $signed({1'b0, d2_ff[j][DL_W-1:0]});
            ph_ff[3*i+j] <= r_ff[3*i+j] * $signed(d2_ff[j][D_W-1:DL_W]);
         end
      end
      if (reset) s3_ff <= '0;
      else       s3_ff <= s2_ff;
   end

   // stage 4: row sums and rounding to q16.16
   qpp_pkg::side_type       s4_ff;
   logic signed [V_W-1:0]   v_ff [3];
   logic signed [ACC_W-1:0] acc  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_W'(36'sd536870912);
         for (int j = 0; j < 3; j++) begin
            acc[i] = acc[i] + (ACC_W'(ph_ff[3*i+j]) <<< DL_W) + ACC_W'(pl_ff[3*i+j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         v_ff[i] <= acc[i][ACC_W-1:30];
      end
      if (reset) s4_ff <= '0;
      else       s4_ff <= s3_ff;
   end

   // stage 5: zero depth, signs and magnitudes
   qpp_pkg::side_type s5_ff;
   qpp_pkg::side_type s5_in;
   logic [V_W-1:0]    den5_ff, mx5_ff, my5_ff;

   always_comb begin
      s5_in       = s4_ff;
      s5_in.dz    = v_ff[0] == '0;
      s5_in.neg_x = v_ff[1][V_W-1] ^ v_ff[0][V_W-1];
      s5_in.neg_y = v_ff[2][V_W-1] ^ v_ff[0][V_W-1];
   end

   always_ff @(posedge clock) begin
      den5_ff <= v_ff[0][V_W-1] ? V_W'(-v_ff[0]) : V_W'(v_ff[0]);
      mx5_ff  <= v_ff[1][V_W-1] ? V_W'(-v_ff[1]) : V_W'(v_ff[1]);
      my5_ff  <= v_ff[2][V_W-1] ? V_W'(-v_ff[2]) : V_W'(v_ff[2]);
      if (reset) s5_ff <= '0;
      else       s5_ff <= s5_in;
   end

   // stage 6: focal partial products
   qpp_pkg::side_type   s6_ff;
   logic [V_W-1:0]      den6_ff;
   logic [ML_W+F_W-1:0] xl_ff, yl_ff;
   logic [MH_W+F_W-1:0] xh_ff, yh_ff;

   always_ff @(posedge clock) begin
      xl_ff   <= mx5_ff[ML_W-1:0] * focal_ff;
      xh_ff   <= mx5_ff[V_W-1:ML_W] * focal_ff;
      yl_ff   <= my5_ff[ML_W-1:0] * focal_ff;
      yh_ff   <= my5_ff[V_W-1:ML_W] * focal_ff;
      den6_ff <= den5_ff;
      if (reset) s6_ff <= '0;
      else       s6_ff <= s5_ff;
   end

   // stage 7: full dividends
   qpp_pkg::side_type s7_ff;
   logic [V_W-1:0]    den7_ff;
   logic [N_W-1:0]    nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      nx_ff   <= (N_W'(xh_ff) << ML_W) + N_W'(xl_ff);
      ny_ff   <= (N_W'(yh_ff) << ML_W) + N_W'(yl_ff);
      den7_ff <= den6_ff;
      if (reset) s7_ff <= '0;
      else       s7_ff <= s6_ff;
   end

   // stage 8: overflow check and divider set-up
   qpp_pkg::side_type s8_ff;
   qpp_pkg::side_type s8_in;
   logic [V_W-1:0]    den8_ff, rx8_ff, ry8_ff;
   logic [CW-1:0]     lx8_ff, ly8_ff;
   logic [N_W+CW-1:0] den_sh;

   assign den_sh = (N_W+CW)'(den7_ff) << CW;

   always_comb begin
      s8_in       = s7_ff;
      s8_in.ovf_x = (N_W+CW)'(nx_ff) >= den_sh;
      s8_in.ovf_y = (N_W+CW)'(ny_ff) >= den_sh;
   end

   always_ff @(posedge clock) begin
      den8_ff <= den7_ff;
      rx8_ff  <= V_W'(nx_ff >> CW);
      ry8_ff  <= V_W'(ny_ff >> CW);
      lx8_ff  <= nx_ff[CW-1:0];
      ly8_ff  <= ny_ff[CW-1:0];
      if (reset) s8_ff <= '0;
      else       s8_ff <= s8_in;
   end

   // divider stages
   logic [CW-1:0] qx, qy;

   qpp_div #(.COORD_WIDTH(CW), .DEN_W(V_W)) u_div_x (
      .clock (clock),
      .den   (den8_ff),
      .rem0  (rx8_ff),
      .low   (lx8_ff),
      .quot  (qx)
   );

   qpp_div #(.COORD_WIDTH(CW), .DEN_W(V_W)) u_div_y (
      .clock (clock),
      .den   (den8_ff),
      .rem0  (ry8_ff),
      .low   (ly8_ff),
      .quot  (qy)
   );

   // control bits follow the divider
   qpp_pkg::side_type sd_ff [CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CW; i++) sd_ff[i] <= '0;
      end else begin
         sd_ff[0] <= s8_ff;
         for (int i = 1; i < CW; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   // sign, clamping and zero depth
   qpp_pkg::side_type sf;
   logic [CW:0]       lim;
   logic [CW-1:0]     sx_in, sy_in;
   logic              satx, saty;

   assign sf  = sd_ff[CW-1];
   assign lim = (CW+1)'(1) << (CW-1);

   always_comb begin
      satx  = 1'b0;
      saty  = 1'b0;
      sx_in = '0;
      sy_in = '0;
      if (sf.ovf_x) begin
         satx  = 1'b1;
         sx_in = sf.neg_x ? lim[CW-1:0] : CW'(lim - 1'b1);
      end else if (qx == '0) begin
         sx_in = '0;
      end else if (sf.neg_x) begin
         if ({1'b0, qx} > lim) begin
            satx  = 1'b1;
            sx_in = lim[CW-1:0];
         end else begin
            sx_in = ~qx + 1'b1;
         end
      end else if ({1'b0, qx} > lim - 1'b1) begin
         satx  = 1'b1;
         sx_in = CW'(lim - 1'b1);
      end else begin
         sx_in = qx;
      end
      if (sf.ovf_y) begin
         saty  = 1'b1;
         sy_in = sf.neg_y ? lim[CW-1:0] : CW'(lim - 1'b1);
      end else if (qy == '0) begin
         sy_in = '0;
      end else if (sf.neg_y) begin
         if ({1'b0, qy} > lim) begin
            saty  = 1'b1;
            sy_in = lim[CW-1:0];
         end else begin
            sy_in = ~qy + 1'b1;
         end
      end else if ({1'b0, qy} > lim - 1'b1) begin
         saty  = 1'b1;
         sy_in = CW'(lim - 1'b1);
      end else begin
         sy_in = qy;
      end
      if (sf.dz) begin
         satx  = 1'b0;
         saty  = 1'b0;
         sx_in = '0;
         sy_in = '0;
      end
   end

   // output register
   logic                 rsp_valid_ff, dz_ff, sat_ff, last_ff;
   logic signed [CW-1:0] sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      dz_ff   <= sf.dz;
      sat_ff  <= satx | saty;
      last_ff <= sf.last;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= sf.valid;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_x   = sx_ff;
   assign rsp_screen_y   = sy_ff;
   assign rsp_depth_zero = dz_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_last_out   = last_ff;

endmodule

>>> sv/qpp_div.sv
// pipelined restoring divider, one quotient bit per stage
// uses no package items
module qpp_div #(
   parameter int COORD_WIDTH = 32,
   parameter int DEN_W       = 41
) (
   input  logic                   clock,
   input  logic [DEN_W-1:0]       den,
   input  logic [DEN_W-1:0]       rem0,
   input  logic [COORD_WIDTH-1:0] low,
   output logic [COORD_WIDTH-1:0] quot
);

   localparam int CW = COORD_WIDTH;

   logic [DEN_W-1:0] rem_ff [CW];
   logic [DEN_W-1:0] den_ff [CW];
   logic [CW-1:0]    low_ff [CW];
   logic [CW-1:0]    q_ff   [CW];

   for (genvar i = 0; i < CW; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev, den_prev, rem_in;
      logic [CW-1:0]    low_prev, q_prev, q_in;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign rem_prev = rem0;
         assign den_prev = den;
         assign low_prev = low;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      // shift in the next dividend bit and try a subtract
      always_comb begin
         trial = {rem_prev, low_prev[CW-1-i]};
         ge    = trial >= {1'b0, den_prev};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
         q_in  = q_prev;
         q_in[CW-1-i] = ge;
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         den_ff[i] <= den_prev;
         low_ff[i] <= low_prev;
         q_ff[i]   <= q_in;
      end
   end

   assign quot = q_ff[CW-1];

endmodule

>>> sv/qpp_checker.sv
// port-level checks of the projection core, bound to the top level
// depends on qpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module qpp_checker #(
   parameter int COORD_WIDTH = qpp_pkg::COORD_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic signed [COORD_WIDTH-1:0]  rsp_screen_x,
   input logic signed [COORD_WIDTH-1:0]  rsp_screen_y,
   input logic                           rsp_depth_zero,
   input logic                           rsp_saturated
);

   localparam int LAT = qpp_pkg::FIXED_STAGES + COORD_WIDTH;
   localparam logic signed [COORD_WIDTH-1:0] SMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] SMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // every accepted item comes out after the fixed latency
   `QPP_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##LAT rsp_valid)

   // no result without an item accepted at the right time
   `QPP_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, LAT))

   // zero depth gives zero coordinates and no clamp
   `QPP_ASSERT_IMP(a_depth_zero, clock, reset, rsp_valid && rsp_depth_zero,
      rsp_screen_x == '0 && rsp_screen_y == '0 && !rsp_saturated)

   // a clamped item shows a range limit on one coordinate
   `QPP_ASSERT_IMP(a_sat_limit, clock, reset, rsp_valid && rsp_saturated,
      rsp_screen_x == SMAX || rsp_screen_x == SMIN || rsp_screen_y == SMAX || rsp_screen_y == SMIN)

endmodule

bind quaternion_perspective_projection_core qpp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_screen_x   (rsp_screen_x),
   .rsp_screen_y   (rsp_screen_y),
   .rsp_depth_zero (rsp_depth_zero),
   .rsp_saturated  (rsp_saturated)
);

>>> bench/tb_top.sv
// self-checking bench for the quaternion rotation and pinhole projection core
// depends on qpp_pkg and quaternion_perspective_projection_core
module tb_top;

   localparam int CW        = 32;
   localparam int LATENCY   = qpp_pkg::FIXED_STAGES + CW;
   localparam int CYCLE_CAP = 400000;

   typedef struct {
      logic signed [CW-1:0] px, py, pz;
      logic                 last;
   } point_type;

   typedef struct {
      logic signed [CW-1:0] sx, sy;
      logic                 dz, sat, last;
   } proj_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [CW-1:0]          req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic                          req_last_in = 1'b0;
   logic                          rsp_valid;
   logic signed [CW-1:0]          rsp_screen_x, rsp_screen_y;
   logic                          rsp_depth_zero, rsp_saturated, rsp_last_out;
   logic                          csr_we = 1'b0;
   logic [qpp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [qpp_pkg::Q_W-1:0]       csr_wdata = '0;

   // camera and quaternion setting as the bench believes it to be
   logic [31:0] cam_cfg [8];

   point_type pending_points[$];
   proj_type  expected_proj[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   int        burst_left = 0;
   int        gap_left = 0;

   quaternion_perspective_projection_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
      .rsp_depth_zero(rsp_depth_zero), .rsp_saturated(rsp_saturated),
      .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // q2.30 product, rounded half up
   function automatic logic signed [127:0] q30_mul(input logic signed [127:0] a,
                                                   input logic signed [127:0] b);
      return (a * b + 128'sd536870912) >>> 30;
   endfunction

   // num * focal / den, truncated toward zero, clamped to the coordinate range
   function automatic logic signed [CW-1:0] perspective_div(input logic signed [127:0] num,
                                                            input logic signed [127:0] den,
                                                            input logic [31:0] f,
                                                            inout logic clamped);
      logic [127:0] mn, md, q, lim;
      logic         neg;
      mn  = num < 0 ? -num : num;
      md  = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      lim = 128'd1 << (CW - 1);
      q   = (mn * {96'd0, f}) / md;
      if (q == 0) return '0;
      if (neg) begin
         if (q > lim) begin
            clamped = 1'b1;
            return lim[CW-1:0];
         end
         return CW'(-q);
      end
      if (q > lim - 1) begin
         clamped = 1'b1;
         return CW'(lim - 1);
      end
      return q[CW-1:0];
   endfunction

   // rotate the camera-relative point and project it onto the screen
   function automatic proj_type project_point(input point_type p);
      logic signed [127:0] w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
      logic signed [127:0] d0, d1, d2, v0, v1, v2, half;
      logic signed [127:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
      logic signed [31:0]  cx, cy, cz;
      proj_type res;
      w = $signed(cam_cfg[qpp_pkg::REG_ROT_QW]); x = $signed(cam_cfg[qpp_pkg::REG_ROT_QX]);
      y = $signed(cam_cfg[qpp_pkg::REG_ROT_QY]); z = $signed(cam_cfg[qpp_pkg::REG_ROT_QZ]);
      cx = cam_cfg[qpp_pkg::REG_CAM_X];
      cy = cam_cfg[qpp_pkg::REG_CAM_Y];
      cz = cam_cfg[qpp_pkg::REG_CAM_Z];
      d0 = p.px; d1 = p.py; d2 = p.pz;
      d0 = d0 - cx; d1 = d1 - cy; d2 = d2 - cz;
      xx = q30_mul(x, x); yy = q30_mul(y, y); zz = q30_mul(z, z);
      xy = q30_mul(x, y); xz = q30_mul(x, z); yz = q30_mul(y, z);
      wx = q30_mul(w, x); wy = q30_mul(w, y); wz = q30_mul(w, z);
      one  = 128'sd1073741824;
      half = 128'sd536870912;
      r00 = one - 2 * (yy + zz); r01 = 2 * (xy - wz); r02 = 2 * (xz + wy);
      r10 = 2 * (xy + wz); r11 = one - 2 * (xx + zz); r12 = 2 * (yz - wx);
      r20 = 2 * (xz - wy); r21 = 2 * (yz + wx); r22 = one - 2 * (xx + yy);
      v0 = (r00 * d0 + r01 * d1 + r02 * d2 + half) >>> 30;
      v1 = (r10 * d0 + r11 * d1 + r12 * d2 + half) >>> 30;
      v2 = (r20 * d0 + r21 * d1 + r22 * d2 + half) >>> 30;
      res.sat  = 1'b0;
      res.last = p.last;
      if (v0 == 0) begin
         res.sx = '0;
         res.sy = '0;
         res.dz = 1'b1;
      end else begin
         res.dz = 1'b0;
         res.sx = perspective_div(v1, v0, cam_cfg[qpp_pkg::REG_FOCAL], res.sat);
         res.sy = perspective_div(v2, v0, cam_cfg[qpp_pkg::REG_FOCAL], res.sat);
      end
      return res;
   endfunction

   // driver: bursts of items with random gaps in between
   always @(posedge clock) begin
      logic      take;
      point_type nxt;
      take = 1'b0;
      cycle_count <= cycle_count + 1;
      if (start && !busy) begin
         expected_proj.push_back(project_point(pending_points.pop_front()));
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         end
      end
      if (reset) begin
         take = 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (pending_points.size() > 0) begin
         take = 1'b1;
         nxt  = pending_points[0];
         req_point_x <= nxt.px;
         req_point_y <= nxt.py;
         req_point_z <= nxt.pz;
         req_last_in <= nxt.last;
      end
      start <= take;
   end

   // monitor: every result strobe against the oldest expectation
   always @(posedge clock) begin
      proj_type e;
      if (!reset && rsp_valid) begin
         if (expected_proj.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            e = expected_proj.pop_front();
            if (rsp_screen_x !== e.sx) begin
               $error("screen_x exp %0d got %0d", e.sx, rsp_screen_x); fail_count++;
            end
            if (rsp_screen_y !== e.sy) begin
               $error("screen_y exp %0d got %0d", e.sy, rsp_screen_y); fail_count++;
            end
            if (rsp_depth_zero !== e.dz) begin
               $error("depth_zero exp %0b got %0b", e.dz, rsp_depth_zero); fail_count++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated); fail_count++;
            end
            if (rsp_last_out !== e.last) begin
               $error("last_out exp %0b got %0b", e.last, rsp_last_out); fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("quaternion_perspective_projection_core: mismatch");
         $finish;
      end
   end

   function automatic point_type mk_point(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic l);
      point_type p;
      p.px = x; p.py = y; p.pz = z; p.last = l;
      return p;
   endfunction

   function automatic logic [31:0] rand_quat();
      longint v;
      v = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
      return v[31:0];
   endfunction

   task automatic drain();
      while (pending_points.size() != 0 || expected_proj.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic csr_write(input qpp_pkg::csr_reg_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cam_cfg[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random points: full range, near the camera, in the camera's x plane, on the camera, extremes
   task automatic queue_random(input int count);
      logic [31:0] c [3];
      logic [31:0] v [3];
      int sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(9, 0);
         for (int k = 0; k < 3; k++) begin
            c[k] = cam_cfg[qpp_pkg::REG_CAM_X + k];
            if (sel < 4)
               v[k] = $urandom;
            else if (sel < 7)
               v[k] = c[k] + $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
            else if (sel < 8)
               v[k] = c[k] + (k == 0 ? 32'd0 : $urandom_range(32'h0004_0000, 0));
            else if (sel < 9)
               v[k] = c[k];
            else
               v[k] = ($urandom_range(1, 0) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
         end
         pending_points.push_back(mk_point(v[0], v[1], v[2], $urandom_range(7, 0) == 0));
      end
   endtask

   // stimulus and configuration sequence
   initial begin
      logic [31:0] setting [8];
      cam_cfg[qpp_pkg::REG_ROT_QW] = 32'h4000_0000;
      for (int k = 1; k < 7; k++) cam_cfg[k] = '0;
      cam_cfg[qpp_pkg::REG_FOCAL] = 32'h0001_0000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (!busy);

      // directed items under the reset setting
      pending_points.push_back(mk_point(32'h0, 32'h0, 32'h0, 1'b0));
      pending_points.push_back(mk_point(32'h0001_0000, 32'h0, 32'h0, 1'b1));
      pending_points.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1'b0));
      pending_points.push_back(mk_point(32'hffff_0000, 32'h0002_0000, 32'h0003_0000, 1'b0));
      pending_points.push_back(mk_point(32'h1, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
      pending_points.push_back(mk_point(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
      pending_points.push_back(mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
      pending_points.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      pending_points.push_back(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0));
      pending_points.push_back(mk_point(32'h0, 32'h0005_0000, 32'h0005_0000, 1'b0));
      pending_points.push_back(mk_point(32'h0000_8000, 32'h0000_4000, 32'hffff_c000, 1'b0));
      pending_points.push_back(mk_point(32'h0010_0000, 32'h0000_0001, 32'hffff_ffff, 1'b1));
      queue_random(120);
      drain();

      // further settings, extremes first then random ones
      for (int ph = 0; ph < 11; ph++) begin
         for (int k = 0; k < 4; k++) setting[k] = rand_quat();
         for (int k = 4; k < 7; k++) setting[k] = ($urandom_range(1, 0) == 1) ? $urandom : '0;
         setting[qpp_pkg::REG_FOCAL] = $urandom_range(32'h0200_0000, 32'h0000_1000);
         case (ph)
            0: begin
               for (int k = 0; k < 4; k++) setting[k] = 32'h4000_0000;
            end
            1: begin
               for (int k = 0; k < 4; k++) setting[k] = 32'hc000_0000;
               setting[qpp_pkg::REG_FOCAL] = 32'hffff_ffff;
            end
            2: begin
               setting[qpp_pkg::REG_ROT_QW] = 32'hc000_0000;
               for (int k = 1; k < 4; k++) setting[k] = '0;
               for (int k = 4; k < 7; k++) setting[k] = 32'h8000_0000;
               setting[qpp_pkg::REG_FOCAL] = '0;
            end
            3: begin
               for (int k = 4; k < 7; k++) setting[k] = 32'h7fff_ffff;
               setting[qpp_pkg::REG_FOCAL] = 32'hffff_ffff;
            end
            4: begin
               setting[qpp_pkg::REG_ROT_QW] = '0;
               setting[qpp_pkg::REG_ROT_QZ] = 32'h4000_0000;
               setting[qpp_pkg::REG_ROT_QX] = '0;
               setting[qpp_pkg::REG_ROT_QY] = '0;
            end
            default: ;
         endcase
         for (int k = 0; k < 8; k++) csr_write(qpp_pkg::csr_reg_type'(k), setting[k]);
         queue_random(145);
         drain();
      end

      if (fail_count == 0)
         $display("quaternion_perspective_projection_core: match");
      else
         $display("quaternion_perspective_projection_core: mismatch");
      $finish;
   end

endmodule
